// ===== rtl/core/eatrm_pkg.sv =====
package eatrm_pkg;

	localparam int ANGLE_FRAC_BITS_DEF = 13;
	localparam int OUT_FRAC_BITS_DEF   = 14;

	// Internal angle and trig format is Q2.30.
	localparam int          IQ        = 30;
	localparam logic [30:0] ONE_Q     = 31'h4000_0000;
	localparam logic [31:0] PI_Q      = 32'd3373259426;
	localparam logic [30:0] HALF_PI_Q = 31'd1686629713;
	localparam logic [32:0] TWO_PI_Q  = 33'd6746518852;
	localparam int          HSTEPS    = 6;

	typedef struct packed {
		logic [31:0] q;
		logic [30:0] u;
		logic        xneg;
		logic        cneg;
		logic [30:0] ts;
		logic [30:0] tc;
	} eatrm_hctx_t;

	// Series divisors k*(k+1), sine chain k = 12..2, cosine chain k = 13..3.
	function automatic logic [7:0] sin_div(input int step);
		logic [7:0] d;
		case (step)
			0: d = 8'd156;
			1: d = 8'd110;
			2: d = 8'd72;
			3: d = 8'd42;
			4: d = 8'd20;
			default: d = 8'd6;
		endcase
		return d;
	endfunction

	function automatic logic [7:0] cos_div(input int step);
		logic [7:0] d;
		case (step)
			0: d = 8'd182;
			1: d = 8'd132;
			2: d = 8'd90;
			3: d = 8'd56;
			4: d = 8'd30;
			default: d = 8'd12;
		endcase
		return d;
	endfunction

	// Reciprocals floor(2^32 / divisor).
	function automatic logic [29:0] sin_rec(input int step);
		logic [29:0] r;
		case (step)
			0: r = 30'd27531841;
			1: r = 30'd39045157;
			2: r = 30'd59652323;
			3: r = 30'd102261126;
			4: r = 30'd214748364;
			default: r = 30'd715827882;
		endcase
		return r;
	endfunction

	function automatic logic [29:0] cos_rec(input int step);
		logic [29:0] r;
		case (step)
			0: r = 30'd23598721;
			1: r = 30'd32537631;
			2: r = 30'd47721858;
			3: r = 30'd76695844;
			4: r = 30'd143165576;
			default: r = 30'd357913941;
		endcase
		return r;
	endfunction

	// Sign times floor(|a|*|b| / 2^30); magnitudes never exceed 2^30 here.
	function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic        neg;
		logic [31:0] ma;
		logic [31:0] mb;
		logic [63:0] p;
		logic [31:0] m;
		neg = a[31] ^ b[31];
		ma  = a[31] ? 32'(-a) : 32'(a);
		mb  = b[31] ? 32'(-b) : 32'(b);
		p   = 64'(ma) * 64'(mb);
		m   = p[61:30];
		return neg ? -$signed(m) : $signed(m);
	endfunction

endpackage

// ===== rtl/core/eatrm_hstep.sv =====
module eatrm_hstep import eatrm_pkg::*; #(
	parameter int STEP = 0
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        vld_i,
	input  eatrm_hctx_t ctx_i,
	output logic        vld_o,
	output eatrm_hctx_t ctx_o
);

	localparam logic [7:0]  SDIV = sin_div(STEP);
	localparam logic [7:0]  CDIV = cos_div(STEP);
	localparam logic [29:0] SREC = sin_rec(STEP);
	localparam logic [29:0] CREC = cos_rec(STEP);

	logic        vld_s1, vld_s2;
	logic [62:0] ps_s1, pc_s1;
	eatrm_hctx_t ctx_s1, ctx_s2;
	logic [31:0] vs_s2, vc_s2;
	logic [29:0] es_s2, ec_s2;

	logic [31:0] vs, vc;
	logic [61:0] mul_s, mul_c;
	logic [37:0] rem_s, rem_c;
	logic [29:0] qs, qc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_o  <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_i;
			vld_s2 <= vld_s1;
			vld_o  <= vld_s2;
		end
	end

	assign vs    = ps_s1[61:30];
	assign vc    = pc_s1[61:30];
	assign mul_s = 62'(vs) * 62'(SREC);
	assign mul_c = 62'(vc) * 62'(CREC);

	// The reciprocal estimate is at most one below the true quotient.
	assign rem_s = 38'(vs_s2) - 38'(es_s2) * 38'(SDIV);
	assign rem_c = 38'(vc_s2) - 38'(ec_s2) * 38'(CDIV);
	assign qs    = es_s2 + 30'(rem_s >= 38'(SDIV));
	assign qc    = ec_s2 + 30'(rem_c >= 38'(CDIV));

	always_ff @(posedge clk) begin
		if (en) begin
			ps_s1  <= 63'(ctx_i.q) * 63'(ctx_i.ts);
			pc_s1  <= 63'(ctx_i.q) * 63'(ctx_i.tc);
			ctx_s1 <= ctx_i;
			vs_s2  <= vs;
			vc_s2  <= vc;
			es_s2  <= mul_s[61:32];
			ec_s2  <= mul_c[61:32];
			ctx_s2 <= ctx_s1;
			ctx_o.q     <= ctx_s2.q;
			ctx_o.u     <= ctx_s2.u;
			ctx_o.xneg  <= ctx_s2.xneg;
			ctx_o.cneg  <= ctx_s2.cneg;
			ctx_o.ts    <= ONE_Q - 31'(qs);
			ctx_o.tc    <= ONE_Q - 31'(qc);
		end
	end

endmodule

// ===== rtl/core/eatrm_sincos.sv =====
module eatrm_sincos import eatrm_pkg::*; #(
	parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               vld_i,
	input  logic signed [15:0] angle,
	output logic               vld_o,
	output logic signed [31:0] sin_o,
	output logic signed [31:0] cos_o
);

	localparam int AW = 46 - ANGLE_FRAC_BITS;
	localparam int MW = (AW > 34) ? AW : 34;
	localparam int NQ = (ANGLE_FRAC_BITS < 13) ? (14 - ANGLE_FRAC_BITS) : 1;
	localparam logic [MW-1:0] TWO_PI_W = MW'(TWO_PI_Q);

	logic [MW-1:0] red_s [NQ+1];
	logic [NQ:0]   rneg_s;
	logic [NQ:0]   rvld_s;

	logic [32:0]   m_f1;
	logic          neg_f1, vld_f1;
	logic [30:0]   u_f2;
	logic          neg_f2, cneg_f2, vld_f2;

	eatrm_hctx_t   ctx_h [HSTEPS+1];
	logic [HSTEPS:0] vld_h;

	logic [61:0]   sp_fa;
	logic [62:0]   cp_fa;
	eatrm_hctx_t   ctx_fa;
	logic          vld_fa;

	logic [15:0]   amag;
	logic [32:0]   m_red;
	logic [61:0]   uu;
	logic [31:0]   s_mag;
	logic signed [31:0] c_val;

	assign amag = angle[15] ? 16'(-angle) : 16'(angle);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rvld_s[0] <= 1'b0;
		end else if (en) begin
			rvld_s[0] <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			red_s[0]  <= MW'(amag) << (IQ - ANGLE_FRAC_BITS);
			rneg_s[0] <= angle[15];
		end
	end

	// Restoring remainder by 2*pi, one quotient bit per stage.
	for (genvar i = 0; i < NQ; i++) begin : g_red
		localparam logic [MW-1:0] D = TWO_PI_W << (NQ - 1 - i);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rvld_s[i+1] <= 1'b0;
			end else if (en) begin
				rvld_s[i+1] <= rvld_s[i];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				red_s[i+1]  <= (red_s[i] >= D) ? red_s[i] - D : red_s[i];
				rneg_s[i+1] <= rneg_s[i];
			end
		end
	end

	assign m_red = red_s[NQ][32:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_f1   <= 1'b0;
			vld_f2   <= 1'b0;
			vld_h[0] <= 1'b0;
			vld_fa   <= 1'b0;
			vld_o    <= 1'b0;
		end else if (en) begin
			vld_f1   <= rvld_s[NQ];
			vld_f2   <= vld_f1;
			vld_h[0] <= vld_f2;
			vld_fa   <= vld_h[HSTEPS];
			vld_o    <= vld_fa;
		end
	end

	assign uu    = 62'(u_f2) * 62'(u_f2);
	assign s_mag = sp_fa[61:30];
	// The last cosine step halves the product, so the shift is one bit longer.
	assign c_val = $signed({1'b0, ONE_Q}) - $signed({1'b0, cp_fa[61:31]});

	always_ff @(posedge clk) begin
		if (en) begin
			// Wrap into [-pi, pi]: above pi the magnitude mirrors and the sign flips.
			if (m_red > 33'(PI_Q)) begin
				m_f1   <= TWO_PI_Q - m_red;
				neg_f1 <= ~rneg_s[NQ];
			end else begin
				m_f1   <= m_red;
				neg_f1 <= rneg_s[NQ];
			end
			// Fold into [-pi/2, pi/2]; the cosine changes sign there.
			if (m_f1 > 33'(HALF_PI_Q)) begin
				u_f2    <= 31'(33'(PI_Q) - m_f1);
				cneg_f2 <= 1'b1;
			end else begin
				u_f2    <= m_f1[30:0];
				cneg_f2 <= 1'b0;
			end
			neg_f2 <= neg_f1;
			ctx_h[0].q    <= uu[61:30];
			ctx_h[0].u    <= u_f2;
			ctx_h[0].xneg <= neg_f2;
			ctx_h[0].cneg <= cneg_f2;
			ctx_h[0].ts   <= ONE_Q;
			ctx_h[0].tc   <= ONE_Q;
			sp_fa  <= 62'(ctx_h[HSTEPS].u) * 62'(ctx_h[HSTEPS].ts);
			cp_fa  <= 63'(ctx_h[HSTEPS].q) * 63'(ctx_h[HSTEPS].tc);
			ctx_fa <= ctx_h[HSTEPS];
			sin_o  <= ctx_fa.xneg ? -$signed(s_mag) : $signed(s_mag);
			cos_o  <= ctx_fa.cneg ? -c_val : c_val;
		end
	end

	for (genvar k = 0; k < HSTEPS; k++) begin : g_horner
		eatrm_hstep #(.STEP(k)) u_step (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.vld_i  (vld_h[k]),
			.ctx_i  (ctx_h[k]),
			.vld_o  (vld_h[k+1]),
			.ctx_o  (ctx_h[k+1])
		);
	end

endmodule

// ===== rtl/core/eatrm_merge.sv =====
module eatrm_merge import eatrm_pkg::*; #(
	parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               vld_i,
	input  logic signed [31:0] sr,
	input  logic signed [31:0] cr,
	input  logic signed [31:0] sp,
	input  logic signed [31:0] cp,
	input  logic signed [31:0] sh,
	input  logic signed [31:0] ch,
	output logic               vld_o,
	output logic [15:0]        elem_o [9]
);

	localparam int SH = IQ - OUT_FRAC_BITS;
	localparam logic [33:0] RND = (SH > 0) ? (34'd1 << (SH - 1)) : 34'd0;
	localparam logic [32:0] LIM = (OUT_FRAC_BITS >= 15) ? 33'd32767 :
		(33'd1 << OUT_FRAC_BITS);

	logic vld_s1, vld_s2, vld_s3;
	logic signed [31:0] spch_s1, spsh_s1, pch_s1, psh_s1, rcp_s1, ccp_s1;
	logic signed [31:0] sr_s1, cr_s1, sh_s1, ch_s1, sp_s1;
	logic signed [31:0] a1_s2, a2_s2, b1_s2, b2_s2, c1_s2, c2_s2, d1_s2, d2_s2;
	logic signed [31:0] pch_s2, psh_s2, sp_s2, rcp_s2, ccp_s2;
	logic signed [32:0] e_s3 [9];

	function automatic logic [15:0] to_out(input logic signed [32:0] v);
		logic        neg;
		logic [32:0] m;
		logic [32:0] r;
		neg = v[32];
		m   = neg ? 33'(-v) : 33'(v);
		m   = 33'((34'(m) + RND) >> SH);
		if (m > LIM) m = LIM;
		r   = neg ? -m : m;
		return r[15:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_o  <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_i;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_o  <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			spch_s1 <= qmul(sp, ch);
			spsh_s1 <= qmul(sp, sh);
			pch_s1  <= qmul(cp, ch);
			psh_s1  <= qmul(cp, sh);
			rcp_s1  <= qmul(sr, cp);
			ccp_s1  <= qmul(cr, cp);
			sr_s1   <= sr;
			cr_s1   <= cr;
			sh_s1   <= sh;
			ch_s1   <= ch;
			sp_s1   <= sp;

			a1_s2  <= qmul(cr_s1, sh_s1);
			a2_s2  <= qmul(sr_s1, spch_s1);
			b1_s2  <= qmul(sr_s1, sh_s1);
			b2_s2  <= qmul(cr_s1, spch_s1);
			c1_s2  <= qmul(cr_s1, ch_s1);
			c2_s2  <= qmul(sr_s1, spsh_s1);
			d1_s2  <= qmul(sr_s1, ch_s1);
			d2_s2  <= qmul(cr_s1, spsh_s1);
			pch_s2 <= pch_s1;
			psh_s2 <= psh_s1;
			sp_s2  <= sp_s1;
			rcp_s2 <= rcp_s1;
			ccp_s2 <= ccp_s1;

			e_s3[0] <= 33'(pch_s2);
			e_s3[1] <= 33'(a2_s2) - 33'(a1_s2);
			e_s3[2] <= 33'(b1_s2) + 33'(b2_s2);
			e_s3[3] <= 33'(psh_s2);
			e_s3[4] <= 33'(c1_s2) + 33'(c2_s2);
			e_s3[5] <= 33'(d2_s2) - 33'(d1_s2);
			e_s3[6] <= -33'(sp_s2);
			e_s3[7] <= 33'(rcp_s2);
			e_s3[8] <= 33'(ccp_s2);

			for (int i = 0; i < 9; i++) begin
				elem_o[i] <= to_out(e_s3[i]);
			end
		end
	end

endmodule

// ===== rtl/core/euler_angles_to_rotation_matrix.sv =====
// Channel   Signals                                            Direction
// input     in_valid, in_stall, roll/pitch/heading_angle       request in
// output    out_valid, out_stall, m00 .. m22                   request out
//
// One request is taken every cycle while in_stall is low. Each angle lane holds
// NQ 2*pi remainder stages (one at the default angle format) and six
// three-stage series steps ahead of the merge stages.
// Reset clears only the valid bits of the pipeline.
// While a finished result is held by out_stall, the whole pipeline holds and
// in_stall is raised.
module euler_angles_to_rotation_matrix import eatrm_pkg::*; #(
	parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
	parameter int OUT_FRAC_BITS   = OUT_FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] roll_angle,
	input  logic signed [15:0] pitch_angle,
	input  logic signed [15:0] heading_angle,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] m00,
	output logic signed [15:0] m01,
	output logic signed [15:0] m02,
	output logic signed [15:0] m10,
	output logic signed [15:0] m11,
	output logic signed [15:0] m12,
	output logic signed [15:0] m20,
	output logic signed [15:0] m21,
	output logic signed [15:0] m22
);

	logic               en;
	logic               lane_vld;
	logic signed [31:0] sr, cr, sp, cp, sh, ch;
	logic [15:0]        elem [9];

	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	eatrm_sincos #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_roll (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_i(in_valid), .angle(roll_angle),
		.vld_o(lane_vld), .sin_o(sr), .cos_o(cr)
	);

	eatrm_sincos #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_pitch (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_i(in_valid), .angle(pitch_angle),
		.vld_o(), .sin_o(sp), .cos_o(cp)
	);

	eatrm_sincos #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_heading (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_i(in_valid), .angle(heading_angle),
		.vld_o(), .sin_o(sh), .cos_o(ch)
	);

	eatrm_merge #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_merge (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_i(lane_vld),
		.sr(sr), .cr(cr), .sp(sp), .cp(cp), .sh(sh), .ch(ch),
		.vld_o(out_valid), .elem_o(elem)
	);

	assign m00 = elem[0];
	assign m01 = elem[1];
	assign m02 = elem[2];
	assign m10 = elem[3];
	assign m11 = elem[4];
	assign m12 = elem[5];
	assign m20 = elem[6];
	assign m21 = elem[7];
	assign m22 = elem[8];

endmodule
